// File: sv/aes256_block_cipher_unit_assert.svh
// assertion macros for the aes256 block cipher unit
`ifndef AES256_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define AES256_BLOCK_CIPHER_UNIT_ASSERT_SVH

// general property, clocked on clk and quiet during reset
`define AES256_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled output transfer keeps its value
`define AES256_HOLD(lbl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (out_valid && !out_ready) |=> $stable(sig)) else $error(msg);

`endif

// File: sv/aes256_pkg.sv
`timescale 1ns / 1ps
package aes256_pkg;

    localparam int NumRounds = 14;
    localparam int NumKeyRegs = 4;

    typedef logic [127:0] state_t;
    typedef logic [7:0] byte_t;

    localparam logic [0:255][7:0] SBOX_FWD = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] SBOX_INV = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
    endfunction

    function automatic state_t mix_state(input state_t s, input logic inv);
        byte_t a [4];
        byte_t x2 [4];
        byte_t x4 [4];
        byte_t x8 [4];
        byte_t m;
        state_t o;
        o = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a[r] = s[127 - 8 * (4 * c + r) -: 8];
                x2[r] = xtime(a[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
            end
            for (int r = 0; r < 4; r++)
            begin
                if (inv)
                    m = (x8[r] ^ x4[r] ^ x2[r])
                      ^ (x8[(r + 1) & 3] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3])
                      ^ (x8[(r + 2) & 3] ^ x4[(r + 2) & 3] ^ a[(r + 2) & 3])
                      ^ (x8[(r + 3) & 3] ^ a[(r + 3) & 3]);
                else
                    m = x2[r] ^ (x2[(r + 1) & 3] ^ a[(r + 1) & 3])
                      ^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
                o[127 - 8 * (4 * c + r) -: 8] = m;
            end
        end
        return o;
    endfunction

endpackage

// File: sv/aes256_round.sv
`timescale 1ns / 1ps
module aes256_round
    import aes256_pkg::*;
(
    input  logic   decrypt,
    input  logic   final_round,
    input  state_t state_in,
    input  state_t round_key,
    output state_t state_out
);

    state_t sub_shift;
    state_t keyed;

    // byte substitution and row shift, both directions
    always_comb
    begin
        sub_shift = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (decrypt)
                    sub_shift[127 - 8 * (4 * c + r) -: 8] =
                        SBOX_INV[state_in[127 - 8 * (r + 4 * ((c - r) & 3)) -: 8]];
                else
                    sub_shift[127 - 8 * (4 * c + r) -: 8] =
                        SBOX_FWD[state_in[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]];
            end
        end
    end

    always_comb
    begin
        keyed = '0;
        if (decrypt)
        begin
            keyed = sub_shift ^ round_key;
            state_out = final_round ? keyed : mix_state(keyed, 1'b1);
        end
        else
        begin
            keyed = final_round ? sub_shift : mix_state(sub_shift, 1'b0);
            state_out = keyed ^ round_key;
        end
    end

endmodule

// File: sv/aes256_block_cipher_unit.sv
`timescale 1ns / 1ps
// one register stage per round plus the initial key addition; throughput: one block per
// cycle when out_ready is high and no key expansion runs, each stage stalls only when full
// round keys come from a sequential expander that runs after reset or any key write,
// during which in_ready stays low
// reset clears the key registers to zero and empties the pipeline
module aes256_block_cipher_unit
    import aes256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [63:0] data_high,
    input  logic [63:0] data_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);

    logic [63:0] key_reg [NumKeyRegs];
    logic [3:0]  kx_cnt_reg, kx_cnt_next;
    logic [7:0]  rc_reg, rc_next;
    logic [0:7][31:0] win_reg, win_next;
    state_t      rk_reg [NumRounds + 1];
    logic        kx_busy;

    logic        v_reg [NumRounds + 1];
    logic        kind_reg [NumRounds + 1];
    state_t      st_reg [NumRounds + 1];
    logic        rdy [NumRounds + 2];
    state_t      rnd_out [NumRounds + 1];
    state_t      first_in;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumKeyRegs; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_we && cfg_index < 3'(NumKeyRegs))
        begin
            key_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // key expansion, eight words per cycle
    assign kx_busy = (kx_cnt_reg != 4'd8);

    always_comb
    begin
        rc_next = rc_reg;
        win_next = win_reg;
        kx_cnt_next = kx_cnt_reg;
        if (kx_busy)
        begin
            kx_cnt_next = kx_cnt_reg + 4'd1;
            if (kx_cnt_reg == 4'd0)
            begin
                win_next = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
                rc_next = 8'h01;
            end
            else
            begin
                win_next[0] = win_reg[0]
                    ^ sub_word({win_reg[7][23:0], win_reg[7][31:24]}) ^ {rc_reg, 24'h0};
                win_next[1] = win_reg[1] ^ win_next[0];
                win_next[2] = win_reg[2] ^ win_next[1];
                win_next[3] = win_reg[3] ^ win_next[2];
                win_next[4] = win_reg[4] ^ sub_word(win_next[3]);
                win_next[5] = win_reg[5] ^ win_next[4];
                win_next[6] = win_reg[6] ^ win_next[5];
                win_next[7] = win_reg[7] ^ win_next[6];
                rc_next = xtime(rc_reg);
            end
        end
        if (cfg_we)
            kx_cnt_next = 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kx_cnt_reg <= 4'd0;
        else
            kx_cnt_reg <= kx_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rc_reg <= rc_next;
        win_reg <= win_next;
        if (kx_busy)
        begin
            rk_reg[{kx_cnt_reg[2:0], 1'b0}] <= win_next[0:3];
            if (kx_cnt_reg[2:0] != 3'd7)
                rk_reg[{kx_cnt_reg[2:0], 1'b1}] <= win_next[4:7];
        end
    end

    // round pipeline
    assign rdy[NumRounds + 1] = out_ready;
    for (genvar i = 0; i <= NumRounds; i++)
    begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i + 1];
    end

    assign in_ready = rdy[0] && !kx_busy;
    assign first_in = {data_high, data_low} ^ (kind ? rk_reg[NumRounds] : rk_reg[0]);
    assign rnd_out[0] = first_in;

    for (genvar i = 1; i <= NumRounds; i++)
    begin : g_round
        aes256_round u_round (
            .decrypt     (kind_reg[i - 1]),
            .final_round (1'(i == NumRounds)),
            .state_in    (st_reg[i - 1]),
            .round_key   (kind_reg[i - 1] ? rk_reg[NumRounds - i] : rk_reg[i]),
            .state_out   (rnd_out[i])
        );
    end

    for (genvar i = 0; i <= NumRounds; i++)
    begin : g_stage
        logic v_in;
        logic k_in;
        if (i == 0)
        begin : g_first
            assign v_in = in_valid && in_ready;
            assign k_in = kind;
        end
        else
        begin : g_rest
            assign v_in = v_reg[i - 1];
            assign k_in = kind_reg[i - 1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (rdy[i])
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i] && v_in)
            begin
                st_reg[i] <= rnd_out[i];
                kind_reg[i] <= k_in;
            end
        end
    end

    assign out_valid = v_reg[NumRounds];
    assign result_high = st_reg[NumRounds][127:64];
    assign result_low = st_reg[NumRounds][63:0];

endmodule

// File: sv/aes256_chk.sv
`timescale 1ns / 1ps
`include "aes256_block_cipher_unit_assert.svh"
module aes256_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_high
);

    `AES256_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")
    `AES256_HOLD(a_out_stable, result_high, "result changed while stalled")
    `AES256_ASSERT(a_kx_start, cfg_we |=> !in_ready, "input taken right after key write")
    `AES256_ASSERT(a_kx_busy, cfg_we |-> ##7 !in_ready, "input taken before round keys ready")

endmodule

bind aes256_block_cipher_unit aes256_chk u_aes256_chk (.*);
